@@ rtl/dcnf_pkg.sv @@
// Package for the DIMACS CNF stream parser: widths, character codes, result kinds, helpers.
`timescale 1ns / 1ps

package dcnf_pkg;

    localparam int unsigned NUM_BITS = 24;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned VALUE_W  = 25;
    localparam int unsigned SEEN_W   = 24;
    localparam int unsigned KPOS_W   = 3;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned MUL_W    = NUM_BITS + DIGIT_W;
    localparam int unsigned EXT_W    = (NUM_BITS > VALUE_W) ? NUM_BITS : VALUE_W;
    localparam int unsigned CMP_W    = (NUM_BITS > SEEN_W) ? NUM_BITS : SEEN_W;
    localparam int unsigned TDATA_W  = ((VALUE_W + 1 + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CH_C     = 8'd99;
    localparam logic [CHAR_W-1:0] CH_F     = 8'd102;
    localparam logic [CHAR_W-1:0] CH_N     = 8'd110;
    localparam logic [CHAR_W-1:0] CH_P     = 8'd112;

    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_LIT     = 3'd0,
        KIND_END     = 3'd1,
        KIND_VARS    = 3'd2,
        KIND_CLAUSES = 3'd3,
        KIND_ERR     = 3'd4
    } t_kind;

    function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

endpackage

@@ rtl/dimacs_cnf_stream_parser_core.sv @@
// DIMACS CNF stream parser: byte-level tokenizer with registered result stage.
`timescale 1ns / 1ps

// Usage:
//   Slave stream takes one ASCII byte per transfer on s_axis_tdata.
//   Master stream gives at most one result per input byte:
//     m_axis_tuser = kind (literal, clause end, variable count, clause count, error),
//     m_axis_tdata = signed value and the all_done flag.
//   Throughput is one byte per cycle while no result is held; the parser state and
//   the output register both load on the clock edge that ends the input transfer.
//   s_axis_tready = !m_axis_tvalid || m_axis_tready, so a held result stalls the
//   input only while the receiver holds m_axis_tready low; no result is dropped.
//   An error, or the clause count reaching the header's target, halts the parser:
//   later bytes are still taken but give no results until reset.
//   Reset (i_rst_n low, synchronous) returns the parser to line start, clears
//   the clause counter and target, and empties the output register.
module dimacs_cnf_stream_parser_core
    import dcnf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CHAR_W-1:0]  s_axis_tdata,   // [7:0] char_in
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [24:0] value, [25] all_done, rest zero
    output logic [KIND_W-1:0]  m_axis_tuser    // [2:0] kind
);

    typedef enum logic [3:0] {
        MODE_LINE_START = 4'd0,
        MODE_COMMENT    = 4'd1,
        MODE_HDR_KEY    = 4'd2,
        MODE_HDR_VAR    = 4'd3,
        MODE_HDR_SP2    = 4'd4,
        MODE_HDR_CLS    = 4'd5,
        MODE_HDR_TAIL   = 4'd6,
        MODE_BODY       = 4'd7,
        MODE_NUM        = 4'd8,
        MODE_HALT       = 4'd9
    } t_mode;

    localparam logic [KPOS_W-1:0] KP_SP1  = 3'd0;
    localparam logic [KPOS_W-1:0] KP_C    = 3'd1;
    localparam logic [KPOS_W-1:0] KP_N    = 3'd2;
    localparam logic [KPOS_W-1:0] KP_F    = 3'd3;
    localparam logic [KPOS_W-1:0] KP_SP2  = 3'd4;
    localparam logic [KPOS_W-1:0] KP_VARS = 3'd5;

    t_mode               r_mode,   n_mode;
    logic [KPOS_W-1:0]   r_kpos,   n_kpos;
    logic [NUM_BITS-1:0] r_acc,    n_acc;
    logic                r_neg,    n_neg;
    logic                r_dseen,  n_dseen;
    logic [NUM_BITS-1:0] r_target, n_target;
    logic                r_tknown, n_tknown;
    logic [SEEN_W-1:0]   r_seen,   n_seen;

    logic                r_out_valid;
    t_kind               r_kind;
    logic [VALUE_W-1:0]  r_value;
    logic                r_done;

    logic                n_emit;
    t_kind               n_kind;
    logic [NUM_BITS-1:0] n_mag;
    logic                n_eneg;
    logic                n_edone;
    logic [VALUE_W-1:0]  n_value;

    logic                in_fire;
    logic [CHAR_W-1:0]   ch;
    logic                nl;
    logic                blank;
    logic                digit;
    logic [DIGIT_W-1:0]  dval;
    logic [NUM_BITS-1:0] first_acc;
    logic [MUL_W-1:0]    mul_acc;
    logic                ovf;
    logic [SEEN_W-1:0]   seen_inc;
    logic [EXT_W-1:0]    mag_ext;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign ch        = s_axis_tdata;
    assign nl        = (ch == CH_NL);
    assign blank     = is_blank(ch);
    assign digit     = is_digit(ch);
    assign dval      = DIGIT_W'(ch - CH_ZERO);
    assign first_acc = NUM_BITS'(dval);
    assign mul_acc   = ({1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}) + MUL_W'(dval);
    assign ovf       = (mul_acc[MUL_W-1:NUM_BITS] != '0);
    assign seen_inc  = (r_seen != SEEN_MAX) ? (r_seen + SEEN_W'(1)) : r_seen;

    always_comb begin
        n_mode   = r_mode;
        n_kpos   = r_kpos;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_dseen  = r_dseen;
        n_target = r_target;
        n_tknown = r_tknown;
        n_seen   = r_seen;
        n_emit   = 1'b0;
        n_kind   = KIND_ERR;
        n_mag    = '0;
        n_eneg   = 1'b0;
        n_edone  = 1'b0;
        unique case (r_mode)
            MODE_LINE_START, MODE_BODY: begin
                if (r_mode == MODE_LINE_START && ch == CH_C) begin
                    n_mode = MODE_COMMENT;
                end else if (r_mode == MODE_LINE_START && ch == CH_P) begin
                    n_mode = MODE_HDR_KEY;
                    n_kpos = KP_SP1;
                end else if (nl) begin
                    n_mode = MODE_LINE_START;
                end else if (blank) begin
                    n_mode = MODE_BODY;
                end else if (ch == CH_MINUS || digit) begin
                    n_mode  = MODE_NUM;
                    n_neg   = (ch == CH_MINUS);
                    n_acc   = digit ? first_acc : '0;
                    n_dseen = digit;
                end else begin
                    n_mode = MODE_HALT;
                    n_emit = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (nl) begin
                    n_mode = MODE_LINE_START;
                end
            end
            MODE_HDR_KEY: begin
                case (r_kpos)
                    KP_SP1: begin
                        if (blank) n_kpos = KP_C;
                        else begin n_mode = MODE_HALT; n_emit = 1'b1; end
                    end
                    KP_C: begin
                        if (ch == CH_C) n_kpos = KP_N;
                        else if (!blank) begin n_mode = MODE_HALT; n_emit = 1'b1; end
                    end
                    KP_N: begin
                        if (ch == CH_N) n_kpos = KP_F;
                        else begin n_mode = MODE_HALT; n_emit = 1'b1; end
                    end
                    KP_F: begin
                        if (ch == CH_F) n_kpos = KP_SP2;
                        else begin n_mode = MODE_HALT; n_emit = 1'b1; end
                    end
                    KP_SP2: begin
                        if (blank) n_kpos = KP_VARS;
                        else begin n_mode = MODE_HALT; n_emit = 1'b1; end
                    end
                    default: begin
                        if (digit) begin
                            n_mode  = MODE_HDR_VAR;
                            n_acc   = first_acc;
                            n_neg   = 1'b0;
                            n_dseen = 1'b1;
                        end else if (!blank) begin
                            n_mode = MODE_HALT;
                            n_emit = 1'b1;
                        end
                    end
                endcase
            end
            MODE_HDR_VAR, MODE_HDR_CLS, MODE_NUM: begin
                if (digit) begin
                    if (ovf) begin
                        n_mode = MODE_HALT;
                        n_emit = 1'b1;
                    end else begin
                        n_acc   = mul_acc[NUM_BITS-1:0];
                        n_dseen = 1'b1;
                    end
                end else if (r_mode == MODE_HDR_VAR && blank) begin
                    n_mode = MODE_HDR_SP2;
                    n_emit = 1'b1;
                    n_kind = KIND_VARS;
                    n_mag  = r_acc;
                end else if (r_mode == MODE_HDR_CLS && (blank || nl)) begin
                    n_target = r_acc;
                    n_tknown = 1'b1;
                    n_emit   = 1'b1;
                    n_kind   = KIND_CLAUSES;
                    n_mag    = r_acc;
                    n_edone  = (CMP_W'(r_seen) >= CMP_W'(r_acc));
                    if (n_edone) n_mode = MODE_HALT;
                    else if (nl) n_mode = MODE_LINE_START;
                    else n_mode = MODE_HDR_TAIL;
                end else if (r_mode == MODE_NUM && (blank || nl) && r_dseen) begin
                    n_mode = nl ? MODE_LINE_START : MODE_BODY;
                    n_emit = 1'b1;
                    if (r_acc != '0) begin
                        n_kind = KIND_LIT;
                        n_mag  = r_acc;
                        n_eneg = r_neg;
                    end else begin
                        n_seen  = seen_inc;
                        n_kind  = KIND_END;
                        n_edone = r_tknown && (CMP_W'(seen_inc) >= CMP_W'(r_target));
                        if (n_edone) n_mode = MODE_HALT;
                    end
                end else begin
                    n_mode = MODE_HALT;
                    n_emit = 1'b1;
                end
            end
            MODE_HDR_SP2: begin
                if (digit) begin
                    n_mode  = MODE_HDR_CLS;
                    n_acc   = first_acc;
                    n_dseen = 1'b1;
                end else if (!blank) begin
                    n_mode = MODE_HALT;
                    n_emit = 1'b1;
                end
            end
            MODE_HDR_TAIL: begin
                if (nl) n_mode = MODE_LINE_START;
                else if (!blank) begin n_mode = MODE_HALT; n_emit = 1'b1; end
            end
            MODE_HALT: begin
                n_mode = MODE_HALT;
            end
            default: begin
                n_mode = MODE_HALT;
            end
        endcase
    end

    assign mag_ext = EXT_W'(n_mag);
    assign n_value = n_eneg ? VALUE_W'(-mag_ext) : VALUE_W'(mag_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LINE_START;
            r_kpos      <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_dseen     <= 1'b0;
            r_target    <= '0;
            r_tknown    <= 1'b0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_mode   <= n_mode;
                r_kpos   <= n_kpos;
                r_acc    <= n_acc;
                r_neg    <= n_neg;
                r_dseen  <= n_dseen;
                r_target <= n_target;
                r_tknown <= n_tknown;
                r_seen   <= n_seen;
            end
            if (in_fire) begin
                r_out_valid <= n_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_fire && n_emit) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_done  <= n_edone;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tdata  = {{(TDATA_W - VALUE_W - 1){1'b0}}, r_done, r_value};

    // Halt is sticky until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_HALT |=> r_mode == MODE_HALT)
        else $error("parser left halt without reset");

    // An error or a done result always halts the parser.
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_emit && (n_kind == KIND_ERR || n_edone)) |=> r_mode == MODE_HALT)
        else $error("error or done result without halt");

    // Clause end and error carry a zero value.
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_END || r_kind == KIND_ERR)) |-> r_value == '0)
        else $error("clause end or error with nonzero value");

    // Done is only flagged on a clause end or a clause count.
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> (r_kind == KIND_END || r_kind == KIND_CLAUSES))
        else $error("done flag on wrong result kind");

    // Clause counter never steps back.
    a_seen_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_seen >= $past(r_seen))
        else $error("clause counter decreased");

endmodule

@@ sim/dimacs_cnf_stream_parser_core_tb.sv @@
// Testbench for dimacs_cnf_stream_parser_core: random CNF text in, token stream checked.
`timescale 1ns / 1ps

module dimacs_cnf_stream_parser_core_tb;
    import dcnf_pkg::*;

    localparam int CALM_BYTES = 120;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [NUM_BITS-1:0] NUM_MAX = {NUM_BITS{1'b1}};

    typedef enum logic [3:0] {
        PM_LINE_START,
        PM_COMMENT,
        PM_HDR_KEY,
        PM_HDR_VAR,
        PM_HDR_SP2,
        PM_HDR_CLS,
        PM_HDR_TAIL,
        PM_BODY,
        PM_NUM,
        PM_HALT
    } t_pmode;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               done;
    } t_token;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [CHAR_W-1:0]  s_axis_tdata = '0;   // [7:0] char_in
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // [24:0] value, [25] all_done, rest zero
    logic [KIND_W-1:0]  m_axis_tuser;        // [2:0] kind

    // parser model state
    t_pmode            pmode = PM_LINE_START;
    logic [2:0]        kpos = '0;
    logic [NUM_BITS-1:0] acc = '0;
    logic              neg = 1'b0;
    logic              got_digit = 1'b0;
    logic [NUM_BITS-1:0] target = '0;
    logic              have_target = 1'b0;
    logic [SEEN_W-1:0] clause_cnt = '0;

    logic [CHAR_W-1:0] text_q[$];
    t_token            token_q[$];
    int                gen_clauses = 0;
    int                total_bytes = 0;
    int                bytes_sent = 0;
    int                errors = 0;
    int                cycles = 0;
    int                send_gap = 0;
    int                hold_left = 0;
    logic              long_hold_done = 1'b0;

    dimacs_cnf_stream_parser_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic take_digit(input logic [CHAR_W-1:0] ch);
        logic [NUM_BITS+3:0] nxt;
        nxt = (NUM_BITS+4)'(acc * 10 + (ch - CH_ZERO));
        if (nxt > NUM_MAX) return 1'b0;
        acc = nxt[NUM_BITS-1:0];
        got_digit = 1'b1;
        return 1'b1;
    endfunction

    task automatic parse_byte(input logic [CHAR_W-1:0] ch, output logic hit,
                              output t_token tok);
        logic blank, digit, nl, ok;
        blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR);
        digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        nl = (ch == CH_NL);
        hit = 1'b0;
        ok = 1'b1;
        tok = '{kind: KIND_ERR, value: '0, done: 1'b0};
        case (pmode)
            PM_LINE_START: begin
                if (ch == CH_C) pmode = PM_COMMENT;
                else if (ch == CH_P) begin
                    pmode = PM_HDR_KEY;
                    kpos = '0;
                end else if (nl) ;
                else if (blank) pmode = PM_BODY;
                else if (ch == CH_MINUS || digit) begin
                    pmode = PM_NUM;
                    acc = '0;
                    got_digit = 1'b0;
                    neg = (ch == CH_MINUS);
                    if (digit) ok = take_digit(ch);
                end else ok = 1'b0;
            end
            PM_COMMENT: if (nl) pmode = PM_LINE_START;
            PM_HDR_KEY: begin
                case (kpos)
                    3'd0: if (blank) kpos = 3'd1; else ok = 1'b0;
                    3'd1: if (ch == CH_C) kpos = 3'd2; else if (!blank) ok = 1'b0;
                    3'd2: if (ch == CH_N) kpos = 3'd3; else ok = 1'b0;
                    3'd3: if (ch == CH_F) kpos = 3'd4; else ok = 1'b0;
                    3'd4: if (blank) kpos = 3'd5; else ok = 1'b0;
                    default: begin
                        if (digit) begin
                            acc = '0;
                            neg = 1'b0;
                            got_digit = 1'b0;
                            ok = take_digit(ch);
                            pmode = PM_HDR_VAR;
                        end else if (!blank) ok = 1'b0;
                    end
                endcase
            end
            PM_HDR_VAR: begin
                if (digit) ok = take_digit(ch);
                else if (blank) begin
                    pmode = PM_HDR_SP2;
                    hit = 1'b1;
                    tok = '{kind: KIND_VARS, value: {1'b0, acc}, done: 1'b0};
                end else ok = 1'b0;
            end
            PM_HDR_SP2: begin
                if (digit) begin
                    acc = '0;
                    got_digit = 1'b0;
                    ok = take_digit(ch);
                    pmode = PM_HDR_CLS;
                end else if (!blank) ok = 1'b0;
            end
            PM_HDR_CLS: begin
                if (digit) ok = take_digit(ch);
                else if (blank || nl) begin
                    target = acc;
                    have_target = 1'b1;
                    hit = 1'b1;
                    tok = '{kind: KIND_CLAUSES, value: {1'b0, acc},
                            done: (clause_cnt >= target)};
                    if (tok.done) pmode = PM_HALT;
                    else pmode = nl ? PM_LINE_START : PM_HDR_TAIL;
                end else ok = 1'b0;
            end
            PM_HDR_TAIL: begin
                if (nl) pmode = PM_LINE_START;
                else if (!blank) ok = 1'b0;
            end
            PM_BODY: begin
                if (nl) pmode = PM_LINE_START;
                else if (ch == CH_MINUS || digit) begin
                    pmode = PM_NUM;
                    acc = '0;
                    got_digit = 1'b0;
                    neg = (ch == CH_MINUS);
                    if (digit) ok = take_digit(ch);
                end else if (!blank) ok = 1'b0;
            end
            PM_NUM: begin
                if (digit) ok = take_digit(ch);
                else if ((blank || nl) && got_digit) begin
                    pmode = nl ? PM_LINE_START : PM_BODY;
                    hit = 1'b1;
                    if (acc != '0) begin
                        tok.kind = KIND_LIT;
                        tok.value = {1'b0, acc};
                        if (neg) tok.value = -tok.value;
                    end else begin
                        if (clause_cnt != SEEN_MAX) clause_cnt = clause_cnt + SEEN_W'(1);
                        tok.kind = KIND_END;
                        tok.done = have_target && (clause_cnt >= target);
                        if (tok.done) pmode = PM_HALT;
                    end
                end else ok = 1'b0;
            end
            default: pmode = PM_HALT;
        endcase
        if (!ok) begin
            pmode = PM_HALT;
            hit = 1'b1;
            tok = '{kind: KIND_ERR, value: '0, done: 1'b0};
        end
    endtask

    task automatic add_byte(input logic [CHAR_W-1:0] b);
        text_q = {text_q, b};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic push_blanks(input int lo, input int hi);
        int n, r;
        n = $urandom_range(hi, lo);
        repeat (n) begin
            r = $urandom_range(0, 5);
            add_byte(r == 0 ? CH_TAB : (r == 1 ? CH_CR : CH_SPACE));
        end
    endtask

    task automatic push_number(input int unsigned mag);
        if ($urandom_range(0, 19) == 0) push_text("00");
        push_text($sformatf("%0d", mag));
    endtask

    task automatic push_literal();
        int r;
        int unsigned mag;
        r = $urandom_range(0, 9);
        if (r < 6) mag = $urandom_range(1, 50);
        else if (r < 9) mag = $urandom_range(1, NUM_MAX);
        else mag = NUM_MAX;
        if ($urandom_range(0, 1)) add_byte(CH_MINUS);
        push_number(mag);
    endtask

    task automatic push_clause_line();
        int n_cl, n_lit, r;
        if ($urandom_range(0, 3) == 0) push_blanks(1, 3);
        n_cl = $urandom_range(1, 3);
        for (int c = 0; c < n_cl; c++) begin
            n_lit = $urandom_range(0, 6);
            repeat (n_lit) begin
                push_literal();
                if ($urandom_range(0, 9) == 0) add_byte(CH_NL);
                else push_blanks(1, 3);
            end
            r = $urandom_range(0, 9);
            if (r == 0) push_text("-0");
            else if (r == 1) push_text("00");
            else push_text("0");
            gen_clauses++;
            if (c != n_cl - 1) push_blanks(1, 2);
        end
        if ($urandom_range(0, 2) == 0) push_blanks(1, 2);
        add_byte(CH_NL);
    endtask

    task automatic push_header(input int unsigned count);
        int r;
        add_byte(CH_P);
        push_blanks(1, 2);
        push_text("cnf");
        push_blanks(1, 2);
        r = $urandom_range(0, 5);
        push_number(r == 0 ? 0 : (r == 1 ? NUM_MAX : $urandom_range(1, 5000)));
        push_blanks(1, 2);
        push_number(count);
        if ($urandom_range(0, 1)) push_blanks(1, 2);
        add_byte(CH_NL);
    endtask

    // stimulus and end of run
    initial begin : stim
        int r, n;
        logic [CHAR_W-1:0] b;

        // comment with extreme bytes, empty line, extreme literals, -0, header
        add_byte(CH_C);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h80);
        add_byte(CH_NL);
        add_byte(CH_NL);
        push_text(" -16777215");
        add_byte(CH_TAB);
        push_text("16777215");
        add_byte(CH_CR);
        push_text("-0");
        add_byte(CH_NL);
        push_text("5");
        add_byte(CH_NL);
        push_text("0");
        add_byte(CH_NL);
        gen_clauses = 2;
        add_byte(CH_P);
        add_byte(CH_TAB);
        push_text(" cnf 0 16777215");
        add_byte(CH_NL);

        while (text_q.size() < 1100) begin
            r = $urandom_range(0, 19);
            if (r <= 10) push_clause_line();
            else if (r <= 13) begin
                add_byte(CH_C);
                n = $urandom_range(0, 20);
                repeat (n) begin
                    b = CHAR_W'($urandom_range(0, 254));
                    if (b >= CH_NL) b = b + 1'b1;
                    add_byte(b);
                end
                add_byte(CH_NL);
            end else if (r <= 15) begin
                if ($urandom_range(0, 3) == 0) push_header(NUM_MAX);
                else push_header(gen_clauses + $urandom_range(500, 100000));
            end else begin
                if ($urandom_range(0, 1)) push_blanks(1, 3);
                add_byte(CH_NL);
            end
        end

        // one halting case closes the run
        case ($urandom_range(0, 7))
            0: push_header($urandom_range(0, gen_clauses));
            1: begin
                push_header(gen_clauses + 2);
                push_text("1 -2 0");
                add_byte(CH_NL);
                push_text("3 0");
                add_byte(CH_NL);
            end
            2: push_text("16777216 ");
            3: push_text("x 1 0");
            4: push_text("- 1 0");
            5: push_text("p cnx 1 1");
            6: push_text("12-3 0");
            default: push_text("p cnf -3 1");
        endcase
        repeat (20) add_byte(CHAR_W'($urandom_range(0, 255)));
        total_bytes = text_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_sent < total_bytes) @(posedge i_clk);
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    // byte sender; the model runs on each accepted transfer
    always @(posedge i_clk) begin : feed
        logic   hit, bus_free, quiet;
        t_token tok;
        if (i_rst_n) begin
            bus_free = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, hit, tok);
                if (hit) token_q = {token_q, tok};
                bytes_sent++;
                bus_free = 1'b1;
            end
            quiet = ((bytes_sent / 150) % 3) == 2;
            if (bus_free) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (text_q.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (text_q.size() > CALM_BYTES && !quiet &&
                             $urandom_range(0, 15) == 0) begin
                    send_gap = $urandom_range(0, 16);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tdata <= text_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // receiver backpressure, with one long hold to fill the block
    always @(posedge i_clk) begin : drain
        logic quiet;
        quiet = ((bytes_sent / 150) % 3) == 2;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!long_hold_done && bytes_sent >= 300) begin
            long_hold_done = 1'b1;
            hold_left = 399;
            m_axis_tready <= 1'b0;
        end else if (text_q.size() > CALM_BYTES && !quiet && $urandom_range(0, 11) == 0) begin
            hold_left = $urandom_range(0, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check
        t_token want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (token_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0d tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                want = token_q.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $display("%0t: kind mismatch: expected %0d actual %0d",
                             $time, want.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[VALUE_W-1:0] !== want.value) begin
                    $display("%0t: value mismatch: expected %0d actual %0d", $time,
                             $signed(want.value), $signed(m_axis_tdata[VALUE_W-1:0]));
                    errors++;
                end
                if (m_axis_tdata[VALUE_W] !== want.done) begin
                    $display("%0t: all_done mismatch: expected %0b actual %0b",
                             $time, want.done, m_axis_tdata[VALUE_W]);
                    errors++;
                end
                if (m_axis_tdata[TDATA_W-1:VALUE_W+1] !== '0) begin
                    $display("%0t: tdata padding mismatch: expected 0 actual %h",
                             $time, m_axis_tdata[TDATA_W-1:VALUE_W+1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
